/* src/assert_macros.svh */
// Assertion macros shared by the RLE halfword decoder modules.
// Expects clk and arst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define RLEHD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition must never be true outside reset.
`define RLEHD_NEVER(label, cond, msg) \
	`RLEHD_ASSERT(label, !(cond), msg)

`endif

/* src/rlehd_pkg.sv */
// Package for the RLE halfword decoder: command type between front and back,
// command codes and default queue depth. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rlehd_pkg;

	localparam int Q_DEPTH = 2;

	localparam int POS_W  = 25;
	localparam int SIZE_W = 24;
	localparam int IDX_W  = 24;
	localparam int CNT_W  = 7;

	localparam logic [1:0] CMD_NONE = 2'd0;
	localparam logic [1:0] CMD_LIT  = 2'd1;
	localparam logic [1:0] CMD_REP  = 2'd2;

	typedef struct packed {
		logic [1:0]       kind;
		logic [POS_W-1:0] pos;
		logic [7:0]       carry;
		logic [7:0]       data;
		logic [7:0]       rlen;
		logic             done;
		logic             herr;
	} cmd_t;

endpackage

`default_nettype wire

/* src/rlehd_front.sv */
// Front end: accepts compressed bytes, tracks header and run state, and
// emits one command per byte. Depends on rlehd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rlehd_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          fire,
	input  wire logic [7:0]    in_byte,
	input  wire logic          block_start,
	output rlehd_pkg::cmd_t    cmd
);
	import rlehd_pkg::*;

	localparam logic [3:0] PH_IDLE    = 4'd0;
	localparam logic [3:0] PH_HDR1    = 4'd1;
	localparam logic [3:0] PH_HDR2    = 4'd2;
	localparam logic [3:0] PH_HDR3    = 4'd3;
	localparam logic [3:0] PH_FLAG    = 4'd4;
	localparam logic [3:0] PH_REPEAT  = 4'd5;
	localparam logic [3:0] PH_LITERAL = 4'd6;
	localparam logic [3:0] PH_DONE    = 4'd7;
	localparam logic [3:0] PH_REJECT  = 4'd8;

	logic [3:0]        phase_q, phase_d;
	logic [SIZE_W-1:0] size_q, size_d;
	logic [POS_W-1:0]  pos_q, pos_d;
	logic [7:0]        lit_q, lit_d;
	logic [7:0]        rlen_q, rlen_d;
	logic [7:0]        carry_q, carry_d;
	logic              run_end;

	always_comb begin
		phase_d = phase_q;
		size_d  = size_q;
		pos_d   = pos_q;
		lit_d   = lit_q;
		rlen_d  = rlen_q;
		carry_d = carry_q;
		run_end = 1'b0;
		cmd     = '0;
		cmd.kind = CMD_NONE;
		if (block_start) begin
			pos_d   = '0;
			carry_d = '0;
			size_d  = '0;
			lit_d   = '0;
			rlen_d  = '0;
			if (in_byte[7:4] != 4'h3) begin
				cmd.herr = 1'b1;
				phase_d  = PH_REJECT;
			end else begin
				phase_d = PH_HDR1;
			end
		end else begin
			case (phase_q)
				PH_HDR1: begin
					size_d  = {16'h0000, in_byte};
					phase_d = PH_HDR2;
				end
				PH_HDR2: begin
					size_d[15:8] = in_byte;
					phase_d      = PH_HDR3;
				end
				PH_HDR3: begin
					size_d[23:16] = in_byte;
					pos_d         = '0;
					run_end       = 1'b1;
				end
				PH_FLAG: begin
					if (in_byte[7]) begin
						rlen_d  = {1'b0, in_byte[6:0]} + 8'd3;
						phase_d = PH_REPEAT;
					end else begin
						lit_d   = {1'b0, in_byte[6:0]} + 8'd1;
						phase_d = PH_LITERAL;
					end
				end
				PH_REPEAT: begin
					cmd.kind  = CMD_REP;
					cmd.pos   = pos_q;
					cmd.carry = carry_q;
					cmd.data  = in_byte;
					cmd.rlen  = rlen_q;
					if (rlen_q[0] ^ pos_q[0])
						carry_d = in_byte;
					pos_d   = pos_q + {{(POS_W-8){1'b0}}, rlen_q};
					rlen_d  = '0;
					run_end = 1'b1;
				end
				PH_LITERAL: begin
					if (pos_q[0]) begin
						cmd.kind  = CMD_LIT;
						cmd.pos   = pos_q;
						cmd.carry = carry_q;
						cmd.data  = in_byte;
					end else begin
						carry_d = in_byte;
					end
					pos_d   = pos_q + 1'b1;
					lit_d   = lit_q - 8'd1;
					run_end = (lit_d == 8'd0);
				end
				default: begin
				end
			endcase
			if (run_end) begin
				if (pos_d >= {1'b0, size_d}) begin
					cmd.done = 1'b1;
					phase_d  = PH_DONE;
				end else begin
					phase_d = PH_FLAG;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			size_q  <= '0;
			pos_q   <= '0;
			lit_q   <= '0;
			rlen_q  <= '0;
			carry_q <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			size_q  <= size_d;
			pos_q   <= pos_d;
			lit_q   <= lit_d;
			rlen_q  <= rlen_d;
			carry_q <= carry_d;
		end
	end

endmodule

`default_nettype wire

/* src/rlehd_queue.sv */
// Short command queue between front and back; lets each side stall alone.
// Depends on rlehd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module rlehd_queue #(
	parameter int DEPTH = rlehd_pkg::Q_DEPTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire rlehd_pkg::cmd_t push_cmd,
	input  wire logic            pop,
	output rlehd_pkg::cmd_t      head,
	output logic                 full,
	output logic                 empty
);
	import rlehd_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          slot_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	`RLEHD_NEVER(a_count_range, count_q > CW'(DEPTH), "queue count above depth")
	`RLEHD_ASSERT(a_push_grows, do_push && !do_pop |=> count_q == $past(count_q) + 1'b1, "push lost")
	`RLEHD_NEVER(a_push_full, push && full, "request pushed into full queue")

endmodule

`default_nettype wire

/* src/rlehd_back.sv */
// Back end: turns queued commands into halfword write and fill results and
// holds them in an output register. Depends on rlehd_pkg, assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module rlehd_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire rlehd_pkg::cmd_t              head,
	input  wire logic                         empty,
	output logic                              pop,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic                              single_valid,
	output logic [rlehd_pkg::IDX_W-1:0]       single_index,
	output logic [15:0]                       single_data,
	output logic                              fill_valid,
	output logic [rlehd_pkg::IDX_W-1:0]       fill_index,
	output logic [7:0]                        fill_byte,
	output logic [rlehd_pkg::CNT_W-1:0]       fill_count,
	output logic                              block_done,
	output logic                              header_error
);
	import rlehd_pkg::*;

	logic              valid_q;
	logic              sv_d, fv_d;
	logic [IDX_W-1:0]  si_d, fi_d;
	logic [15:0]       sd_d;
	logic [7:0]        fb_d;
	logic [CNT_W-1:0]  fc_d;
	logic [POS_W-1:0]  fpos;
	logic [7:0]        remain;

	logic              sv_q, fv_q, done_q, herr_q;
	logic [IDX_W-1:0]  si_q, fi_q;
	logic [15:0]       sd_q;
	logic [7:0]        fb_q;
	logic [CNT_W-1:0]  fc_q;

	assign pop = !empty && (!valid_q || out_ready);

	always_comb begin
		fpos   = head.pos + {{(POS_W-1){1'b0}}, head.pos[0]};
		remain = head.rlen - {7'd0, head.pos[0]};
		sv_d   = (head.kind == CMD_LIT || head.kind == CMD_REP) && head.pos[0];
		si_d   = sv_d ? head.pos[POS_W-1:1] : '0;
		sd_d   = sv_d ? {head.data, head.carry} : '0;
		fv_d   = (head.kind == CMD_REP) && (remain[7:1] != '0);
		fi_d   = fv_d ? fpos[POS_W-1:1] : '0;
		fb_d   = fv_d ? head.data : '0;
		fc_d   = fv_d ? remain[7:1] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (pop)
			valid_q <= 1'b1;
		else if (out_ready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			sv_q   <= sv_d;
			si_q   <= si_d;
			sd_q   <= sd_d;
			fv_q   <= fv_d;
			fi_q   <= fi_d;
			fb_q   <= fb_d;
			fc_q   <= fc_d;
			done_q <= head.done;
			herr_q <= head.herr;
		end
	end

	assign out_valid    = valid_q;
	assign single_valid = sv_q;
	assign single_index = si_q;
	assign single_data  = sd_q;
	assign fill_valid   = fv_q;
	assign fill_index   = fi_q;
	assign fill_byte    = fb_q;
	assign fill_count   = fc_q;
	assign block_done   = done_q;
	assign header_error = herr_q;

	`RLEHD_ASSERT(a_fill_count, valid_q && fv_q |-> fc_q != '0, "fill with zero count")
	`RLEHD_NEVER(a_pop_stall, pop && valid_q && !out_ready, "result overwritten while stalled")
	`RLEHD_NEVER(a_herr_alone, valid_q && herr_q && (sv_q || fv_q || done_q), "header error with writes")

endmodule

`default_nettype wire

/* src/rle_halfword_decoder.sv */
// RLE halfword decoder: byte-stream run-length decompressor issuing halfword
// writes and fills. Top level; depends on rlehd_pkg, front, queue and back.
//
// Usage:
//  Input channel (in_valid/in_ready): one compressed byte per request, with
//  block_start marking header byte 0 of a new block.
//  Output channel (out_valid/out_ready): exactly one result per input byte,
//  in order: an optional single halfword write, an optional fill command,
//  block_done and header_error flags. Fields not in use read as zero.
//  Path: an accepted byte's command enters the queue, then the output register.
//  Throughput: one byte per cycle while the queue is not full; the front updates
//  run state per accepted byte, the back formats the command into the output register.
//  Receiver stall: the output register holds its result, the command queue
//  (QDEPTH entries) absorbs further bytes, then in_ready drops.
//  Reset: arst_n clears decoder state to idle; bytes before a block start
//  produce all-zero results.
`timescale 1ns / 1ps
`default_nettype none

module rle_halfword_decoder #(
	parameter int QDEPTH = rlehd_pkg::Q_DEPTH
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [7:0]                   in_byte,
	input  wire logic                         block_start,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic                              single_valid,
	output logic [rlehd_pkg::IDX_W-1:0]       single_index,
	output logic [15:0]                       single_data,
	output logic                              fill_valid,
	output logic [rlehd_pkg::IDX_W-1:0]       fill_index,
	output logic [7:0]                        fill_byte,
	output logic [rlehd_pkg::CNT_W-1:0]       fill_count,
	output logic                              block_done,
	output logic                              header_error
);
	import rlehd_pkg::*;

	cmd_t front_cmd, head;
	logic fire, full, empty, pop;

	assign in_ready = !full;
	assign fire     = in_valid && in_ready;

	rlehd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.in_byte    (in_byte),
		.block_start(block_start),
		.cmd        (front_cmd)
	);

	rlehd_queue #(
		.DEPTH(QDEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (fire),
		.push_cmd(front_cmd),
		.pop     (pop),
		.head    (head),
		.full    (full),
		.empty   (empty)
	);

	rlehd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.empty       (empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.single_valid(single_valid),
		.single_index(single_index),
		.single_data (single_data),
		.fill_valid  (fill_valid),
		.fill_index  (fill_index),
		.fill_byte   (fill_byte),
		.fill_count  (fill_count),
		.block_done  (block_done),
		.header_error(header_error)
	);

endmodule

`default_nettype wire

/* dv/rle_halfword_decoder_tb.sv */
// Self-checking testbench for rle_halfword_decoder: directed table plus random
// compressed streams, checked against table results or an in-bench decoder model.
// Depends on rlehd_pkg and the rle_halfword_decoder RTL.
`timescale 1ns / 1ps

module rle_halfword_decoder_tb;

	import rlehd_pkg::*;

	localparam int          RANDOM_ITEMS = 1300;
	localparam int          LONG_HOLD    = 200;
	localparam int          MAX_REPORTS  = 10;
	localparam logic [3:0]  RLE_TYPE     = 4'h3;
	localparam logic [7:0]  MIN_REPEAT   = 8'd3;

	typedef enum logic [3:0] {
		ST_IDLE, ST_HDR1, ST_HDR2, ST_HDR3, ST_FLAG,
		ST_REPEAT, ST_LITERAL, ST_DONE, ST_REJECT
	} dec_phase_t;

	typedef struct packed {
		logic              single_valid;
		logic [IDX_W-1:0]  single_index;
		logic [15:0]       single_data;
		logic              fill_valid;
		logic [IDX_W-1:0]  fill_index;
		logic [7:0]        fill_byte;
		logic [CNT_W-1:0]  fill_count;
		logic              block_done;
		logic              header_error;
	} halfword_cmd_t;

	typedef struct packed {
		logic [7:0]     data;
		logic           start;
		logic           typed;
		halfword_cmd_t  want;
	} stim_row_t;

	localparam halfword_cmd_t CMD_ZERO = '0;
	localparam halfword_cmd_t CMD_HERR = '{header_error: 1'b1, default: '0};
	localparam halfword_cmd_t CMD_DONE = '{block_done: 1'b1, default: '0};

	localparam int DIR_ROWS = 25;
	localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
		'{8'hFF, 1'b0, 1'b1, CMD_ZERO},	// before any block
		'{8'h20, 1'b1, 1'b1, CMD_HERR},	// bad type
		'{8'h3F, 1'b1, 1'b1, CMD_ZERO},
		'{8'h00, 1'b0, 1'b1, CMD_ZERO},
		'{8'h00, 1'b0, 1'b1, CMD_ZERO},
		'{8'h00, 1'b0, 1'b1, CMD_DONE},	// zero size
		'{8'h55, 1'b0, 1'b1, CMD_ZERO},	// after done
		'{8'h30, 1'b1, 1'b0, CMD_ZERO},
		'{8'hFF, 1'b0, 1'b0, CMD_ZERO},	// max size
		'{8'hFF, 1'b0, 1'b0, CMD_ZERO},
		'{8'hFF, 1'b0, 1'b0, CMD_ZERO},
		'{8'h80, 1'b0, 1'b0, CMD_ZERO},	// shortest repeat, even pos
		'{8'hFF, 1'b0, 1'b0, CMD_ZERO},
		'{8'hFF, 1'b0, 1'b0, CMD_ZERO},	// longest repeat, odd pos
		'{8'h00, 1'b0, 1'b0, CMD_ZERO},
		'{8'h00, 1'b0, 1'b0, CMD_ZERO},	// literal of one
		'{8'hA5, 1'b0, 1'b0, CMD_ZERO},
		'{8'h81, 1'b0, 1'b0, CMD_ZERO},
		'{8'h5A, 1'b0, 1'b0, CMD_ZERO},
		'{8'h35, 1'b1, 1'b0, CMD_ZERO},	// restart mid-block
		'{8'h01, 1'b0, 1'b0, CMD_ZERO},
		'{8'h00, 1'b0, 1'b0, CMD_ZERO},
		'{8'h00, 1'b0, 1'b0, CMD_ZERO},
		'{8'h00, 1'b0, 1'b0, CMD_ZERO},
		'{8'hAB, 1'b0, 1'b0, CMD_ZERO}	// trailing odd byte, done
	};

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              in_valid    = 1'b0;
	logic              in_ready;
	logic [7:0]        in_byte     = '0;
	logic              block_start = 1'b0;
	logic              out_valid;
	logic              out_ready   = 1'b0;
	logic              single_valid;
	logic [IDX_W-1:0]  single_index;
	logic [15:0]       single_data;
	logic              fill_valid;
	logic [IDX_W-1:0]  fill_index;
	logic [7:0]        fill_byte;
	logic [CNT_W-1:0]  fill_count;
	logic              block_done;
	logic              header_error;

	rle_halfword_decoder u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_byte     (in_byte),
		.block_start (block_start),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.single_valid(single_valid),
		.single_index(single_index),
		.single_data (single_data),
		.fill_valid  (fill_valid),
		.fill_index  (fill_index),
		.fill_byte   (fill_byte),
		.fill_count  (fill_count),
		.block_done  (block_done),
		.header_error(header_error)
	);

	always #4 clk = ~clk;

	// decoder model state
	dec_phase_t        dec_phase = ST_IDLE;
	logic [SIZE_W-1:0] dec_size  = '0;
	logic [POS_W-1:0]  dec_pos   = '0;
	logic [7:0]        lit_left  = '0;
	logic [7:0]        rep_len   = '0;
	logic [7:0]        carry     = '0;

	halfword_cmd_t expected_cmds [$];
	int            err_count     = 0;
	int            sent_count    = 0;
	logic          hold_request  = 1'b0;
	logic          rx_holding    = 1'b0;

	function automatic logic close_run();
		if (dec_pos >= POS_W'(dec_size)) begin
			dec_phase = ST_DONE;
			return 1'b1;
		end
		dec_phase = ST_FLAG;
		return 1'b0;
	endfunction

	function automatic halfword_cmd_t decode_byte(input logic [7:0] b, input logic s);
		halfword_cmd_t     r;
		logic [POS_W-1:0]  pos;
		logic [7:0]        remain;
		r = '0;
		if (s) begin
			dec_pos  = '0;
			carry    = '0;
			dec_size = '0;
			lit_left = '0;
			rep_len  = '0;
			if (b[7:4] != RLE_TYPE) begin
				r.header_error = 1'b1;
				dec_phase = ST_REJECT;
			end else begin
				dec_phase = ST_HDR1;
			end
			return r;
		end
		case (dec_phase)
			ST_HDR1: begin
				dec_size[7:0] = b;
				dec_phase = ST_HDR2;
			end
			ST_HDR2: begin
				dec_size[15:8] = b;
				dec_phase = ST_HDR3;
			end
			ST_HDR3: begin
				dec_size[23:16] = b;
				dec_pos = '0;
				r.block_done = close_run();
			end
			ST_FLAG: begin
				if (b[7]) begin
					rep_len = {1'b0, b[6:0]} + MIN_REPEAT;
					dec_phase = ST_REPEAT;
				end else begin
					lit_left = {1'b0, b[6:0]} + 8'd1;
					dec_phase = ST_LITERAL;
				end
			end
			ST_REPEAT: begin
				pos = dec_pos;
				remain = rep_len;
				if (pos[0]) begin
					r.single_valid = 1'b1;
					r.single_index = pos[POS_W-1:1];
					r.single_data  = {b, carry};
					pos = pos + 1'b1;
					remain = remain - 8'd1;
				end
				if (remain[7:1] != '0) begin
					r.fill_valid = 1'b1;
					r.fill_index = pos[POS_W-1:1];
					r.fill_byte  = b;
					r.fill_count = remain[7:1];
				end
				if (remain[0])
					carry = b;
				dec_pos = dec_pos + POS_W'(rep_len);
				rep_len = '0;
				r.block_done = close_run();
			end
			ST_LITERAL: begin
				if (dec_pos[0]) begin
					r.single_valid = 1'b1;
					r.single_index = dec_pos[POS_W-1:1];
					r.single_data  = {b, carry};
				end else begin
					carry = b;
				end
				dec_pos = dec_pos + 1'b1;
				lit_left = lit_left - 8'd1;
				if (lit_left == '0)
					r.block_done = close_run();
			end
			default: ;
		endcase
		return r;
	endfunction

	// mostly short gaps, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic string fmt_cmd(input halfword_cmd_t c);
		return $sformatf("single=%0b idx=%0h data=%0h fill=%0b idx=%0h byte=%0h cnt=%0d done=%0b herr=%0b",
			c.single_valid, c.single_index, c.single_data, c.fill_valid, c.fill_index,
			c.fill_byte, c.fill_count, c.block_done, c.header_error);
	endfunction

	task automatic send_request(input logic [7:0] b, input logic s);
		int gap;
		gap = (hold_request || rx_holding || (sent_count % 128) < 24) ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		in_byte     <= b;
		block_start <= s;
		do @(posedge clk); while (!in_ready);
		sent_count++;
	endtask

	// receiver
	initial begin : receiver
		int run;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				rx_holding = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				rx_holding = 1'b0;
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 40)) @(posedge clk);
			run = pick_gap();
			if (run > 0) begin
				out_ready <= 1'b0;
				repeat (run) @(posedge clk);
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		halfword_cmd_t got;
		halfword_cmd_t want;
		got = '{single_valid, single_index, single_data, fill_valid, fill_index,
			fill_byte, fill_count, block_done, header_error};
		if (arst_n && out_valid && out_ready) begin
			if (expected_cmds.size() == 0) begin
				err_count++;
				if (err_count <= MAX_REPORTS)
					$display("%0t: unexpected result: %s", $realtime, fmt_cmd(got));
			end else begin
				want = expected_cmds.pop_front();
				if (got !== want) begin
					err_count++;
					if (err_count <= MAX_REPORTS) begin
						$display("%0t: mismatch", $realtime);
						$display("  expected: %s", fmt_cmd(want));
						$display("  actual:   %s", fmt_cmd(got));
					end
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : stimulus
		halfword_cmd_t pred;
		logic [7:0]    nb;
		logic          ns;
		logic          idle_byte;
		int            counted;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (DIR_TABLE[i]) begin
			send_request(DIR_TABLE[i].data, DIR_TABLE[i].start);
			pred = decode_byte(DIR_TABLE[i].data, DIR_TABLE[i].start);
			expected_cmds.push_back(DIR_TABLE[i].typed ? DIR_TABLE[i].want : pred);
		end

		// well-formed blocks with random content, some noise and aborted blocks
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			ns = 1'b0;
			nb = 8'($urandom);
			case (dec_phase)
				ST_IDLE, ST_DONE, ST_REJECT: begin
					if ($urandom_range(0, 9) < 8) begin
						ns = 1'b1;
						if ($urandom_range(0, 9) != 0)
							nb = {RLE_TYPE, nb[3:0]};
					end else begin
						ns = ($urandom_range(0, 19) == 0);
					end
				end
				ST_HDR1: ;
				ST_HDR2: nb = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 3)) : 8'h00;
				ST_HDR3: if ($urandom_range(0, 49) != 0) nb = 8'h00;
				default: begin
					ns = ($urandom_range(0, 99) == 0);
					if (ns && $urandom_range(0, 3) != 0)
						nb = {RLE_TYPE, nb[3:0]};
				end
			endcase
			idle_byte = !ns && (dec_phase inside {ST_IDLE, ST_DONE, ST_REJECT});
			if (!idle_byte)
				counted++;
			if (counted == 400)
				hold_request = 1'b1;
			send_request(nb, ns);
			expected_cmds.push_back(decode_byte(nb, ns));
		end
		in_valid <= 1'b0;

		while (expected_cmds.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* sim.f */
+incdir+src
src/rlehd_pkg.sv
src/rlehd_front.sv
src/rlehd_queue.sv
src/rlehd_back.sv
src/rle_halfword_decoder.sv
dv/rle_halfword_decoder_tb.sv
